// ----- design/ckpt_pkg.sv -----
// Shared widths, codes, defaults and control types of the checkpoint slot manager.
package ckpt_pkg;

    localparam int STEP_W      = 12;
    localparam int MODE_W      = 3;
    localparam int SLOT_W      = 12;
    localparam int NSTEPS_W    = 13;
    localparam int NEAR_W      = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_PAD_W   = OUT_DATA_W - (1 + 1 + SLOT_W + 1 + SLOT_W + 1 + 1 + NEAR_W);

    // Default step capacity and the reach of the step field.
    localparam int MAX_STEPS_DEF = 4096;
    localparam int STEP_SPACE    = 2 ** STEP_W;

    // The mark store is organized in rows of ROW_W marks.
    localparam int ROW_W  = 64;
    localparam int ROW_BW = 6;

    localparam logic [STEP_W-1:0]   MIN_INTERVAL    = 12'd3;
    localparam logic [NSTEPS_W-1:0] NUM_STEPS_RST   = 13'd4096;
    localparam logic [STEP_W-1:0]   INTERVAL_RST    = 12'd3;
    localparam logic [SLOT_W-1:0]   BASE_RST        = 12'd0;
    localparam logic [NEAR_W-1:0]   NEAR_NONE       = 13'h1FFF;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_SAVE_PAIR    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESTORE_PAIR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAVE_STEP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GET_STEP     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY        = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR        = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd2;

    // Control strobes from the sequencer to the mark store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } ckpt_mem_ctl_t;

endpackage

// ----- design/ckpt_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle for step / interval.
module ckpt_div
    import ckpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic              done,
    output logic [STEP_W-1:0] quo,
    output logic [STEP_W-1:0] rem
);

    localparam int CNT_W = $clog2(STEP_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W:0]   trial;
    logic              fits;

    // The partial remainder with the next dividend bit shifted in.
    assign trial = {rem_reg, quo_reg[STEP_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEP_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[STEP_W-2:0], fits};
            rem_next = fits ? STEP_W'(trial - {1'b0, dvs_reg}) : trial[STEP_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/ckpt_marks.sv -----
// Stored-marks memory: rows of marks with one row-occupied flag per row.
module ckpt_marks
    import ckpt_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    localparam int DEPTH    = (MAX_STEPS < STEP_SPACE) ? MAX_STEPS : STEP_SPACE,
    localparam int NUM_ROWS = (DEPTH + ROW_W - 1) / ROW_W,
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
    localparam int ROWS     = 2 ** ROW_AW
)(
    input  logic              clk,
    input  logic              rst_n,
    input  ckpt_mem_ctl_t     ctl,
    input  logic [ROW_AW-1:0] rd_row,
    input  logic [ROW_AW-1:0] wr_row,
    input  logic [ROW_W-1:0]  wr_data,
    output logic [ROW_W-1:0]  rd_data,
    output logic [ROWS-1:0]   occupied
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_occ_reg;
    logic [ROWS-1:0]  occ_reg, occ_next;

    // A row whose flag is clear reads as all zero, whatever the memory holds.
    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.clear)
        begin
            occ_next = '0;
        end
        else if (ctl.wr_en)
        begin
            occ_next[wr_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_row];
            rd_occ_reg  <= occ_reg[rd_row];
        end
    end

    assign rd_data  = rd_occ_reg ? rd_data_reg : '0;
    assign occupied = occ_reg;

endmodule

// ----- design/checkpoint_slot_manager_top.sv -----
// Checkpoint slot manager: step-to-slot mapping and stored-mark bookkeeping.
// Clear, unknown-mode and out-of-range requests go straight to the output register; a
// query reads the step's mark row and, if needed, a lower one; slot requests wait for
// the divider; saves add the read-modify-write of the mark rows. One request is in work
// at a time: the next is taken only once the last result is in the output register.
// Reset (rst_n, asynchronous, active low) clears all marks at once through the row flags.
module checkpoint_slot_manager_top
    import ckpt_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] step, rest zero
    input  logic [MODE_W-1:0]     s_axis_tuser,   // [2:0] mode
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] out_of_range, [1] first_valid,
                                                  // [13:2] first_slot, [14] second_valid,
                                                  // [26:15] second_slot, [27] zero_fill,
                                                  // [28] already_stored,
                                                  // [41:29] nearest_stored, rest zero
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH    = (MAX_STEPS < STEP_SPACE) ? MAX_STEPS : STEP_SPACE;
    localparam int NUM_ROWS = (DEPTH + ROW_W - 1) / ROW_W;
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ROWS     = 2 ** ROW_AW;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_SLOT = 9'b000000100,
        S_MRD  = 9'b000001000,
        S_MWR  = 9'b000010000,
        S_QRD  = 9'b000100000,
        S_QCHK = 9'b001000000,
        S_QLOW = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;

    // Configuration registers.
    logic [NSTEPS_W-1:0]   num_steps_reg, num_steps_next;
    logic [STEP_W-1:0]     interval_reg, interval_next;
    logic [SLOT_W-1:0]     base_reg, base_next;

    // Request in work.
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [STEP_W-1:0]     mark_step_reg, mark_step_next;
    logic                  mark_pend_reg, mark_pend_next;
    logic [ROW_AW-1:0]     low_row_reg, low_row_next;

    // Result fields under construction.
    logic                  oor_reg, oor_next;
    logic                  fv_reg, fv_next;
    logic [SLOT_W-1:0]     fs_reg, fs_next;
    logic                  sv_reg, sv_next;
    logic [SLOT_W-1:0]     ss_reg, ss_next;
    logic                  zf_reg, zf_next;
    logic                  as_reg, as_next;
    logic [NEAR_W-1:0]     near_reg, near_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  in_accept;
    logic [MODE_W-1:0]     in_mode;
    logic [STEP_W-1:0]     in_step;
    logic                  in_oor;
    logic [STEP_W-1:0]     d_eff;

    logic                  div_start;
    logic                  div_done;
    logic [STEP_W-1:0]     div_quo;
    logic [STEP_W-1:0]     div_rem;

    ckpt_mem_ctl_t         mem_ctl;
    logic [ROW_AW-1:0]     rd_row;
    logic [ROW_AW-1:0]     mark_row;
    logic [ROW_W-1:0]      mark_wdata;
    logic [ROW_W-1:0]      rd_data;
    logic [ROWS-1:0]       occupied;

    logic [ROW_AW-1:0]     step_row;
    logic [ROW_BW-1:0]     step_bit;
    logic [SLOT_W-1:0]     slot_even;
    logic [SLOT_W-1:0]     slot_odd;
    logic [SLOT_W-1:0]     slot_rot;
    logic [SLOT_W-1:0]     slot_one;

    logic                  below_found;
    logic [ROW_BW-1:0]     below_bit;
    logic                  low_found;
    logic [ROW_AW-1:0]     low_row;
    logic [ROW_BW-1:0]     top_bit;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_mode       = s_axis_tuser;
    assign in_step       = s_axis_tdata[STEP_W-1:0];

    // A step is rejected at or beyond num_steps, or beyond the mark store.
    assign in_oor = ({1'b0, in_step} >= num_steps_reg) || (32'(in_step) >= MAX_STEPS);

    // Intervals below three are treated as three.
    assign d_eff = (interval_reg < MIN_INTERVAL) ? MIN_INTERVAL : interval_reg;

    assign step_row = step_reg[ROW_BW +: ROW_AW];
    assign step_bit = step_reg[ROW_BW-1:0];
    assign mark_row = mark_step_reg[ROW_BW +: ROW_AW];

    // Setting a mark: the row as read, with one more bit set.
    assign mark_wdata = rd_data | (ROW_W'(1) << mark_step_reg[ROW_BW-1:0]);

    // Slot of one step from its quotient and remainder by the interval. A step just
    // before a checkpoint shares the checkpoint's pair of fixed slots.
    assign slot_even = SLOT_W'({div_quo, 1'b0});
    assign slot_odd  = SLOT_W'({div_quo, 1'b1});
    assign slot_rot  = SLOT_W'(base_reg + div_rem - 1'b1);

    always_comb
    begin
        if (div_rem == '0)
        begin
            slot_one = slot_even;
        end
        else if (div_rem == STEP_W'(d_eff - 1'b1))
        begin
            slot_one = slot_odd;
        end
        else
        begin
            slot_one = slot_rot;
        end
    end

    // Highest mark in the step's own row strictly below the step.
    always_comb
    begin
        below_found = 1'b0;
        below_bit   = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (rd_data[i] && (ROW_BW'(i) < step_bit))
            begin
                below_found = 1'b1;
                below_bit   = ROW_BW'(i);
            end
        end
    end

    // Highest occupied row below the step's row.
    always_comb
    begin
        low_found = 1'b0;
        low_row   = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            if (occupied[i] && (ROW_AW'(i) < step_row))
            begin
                low_found = 1'b1;
                low_row   = ROW_AW'(i);
            end
        end
    end

    // Highest mark of the row read from below; the row is known to be non-empty.
    always_comb
    begin
        top_bit = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (rd_data[i])
            begin
                top_bit = ROW_BW'(i);
            end
        end
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_comb
    begin
        num_steps_next = num_steps_reg;
        interval_next  = interval_reg;
        base_next      = base_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_STEPS: num_steps_next = cfg_wdata;
                CFG_INTERVAL:  interval_next  = cfg_wdata[STEP_W-1:0];
                CFG_BASE:      base_next      = cfg_wdata[SLOT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        step_next      = step_reg;
        mark_step_next = mark_step_reg;
        mark_pend_next = mark_pend_reg;
        low_row_next   = low_row_reg;
        oor_next       = oor_reg;
        fv_next        = fv_reg;
        fs_next        = fs_reg;
        sv_next        = sv_reg;
        ss_next        = ss_reg;
        zf_next        = zf_reg;
        as_next        = as_reg;
        near_next      = near_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        mem_ctl        = '0;
        rd_row         = mark_row;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next = in_mode;
                    step_next = in_step;
                    oor_next  = 1'b0;
                    fv_next   = 1'b0;
                    fs_next   = '0;
                    sv_next   = 1'b0;
                    ss_next   = '0;
                    zf_next   = 1'b0;
                    as_next   = 1'b0;
                    near_next = NEAR_NONE;
                    if (in_mode == MODE_CLEAR)
                    begin
                        mem_ctl.clear = 1'b1;
                        state_next    = S_FIN;
                    end
                    else if (in_mode > MODE_QUERY)
                    begin
                        state_next = S_FIN;
                    end
                    else if (in_oor)
                    begin
                        oor_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else if (in_mode == MODE_QUERY)
                    begin
                        state_next = S_QRD;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SLOT;
                end
            end

            S_SLOT:
            begin
                state_next = S_FIN;
                case (mode_reg) inside
                    MODE_SAVE_PAIR, MODE_RESTORE_PAIR:
                    begin
                        // Only checkpoint steps are acted on.
                        if (div_rem == '0)
                        begin
                            sv_next = 1'b1;
                            ss_next = slot_even;
                            if (step_reg != '0)
                            begin
                                fv_next = 1'b1;
                                fs_next = SLOT_W'(slot_even - 1'b1);
                            end
                            else if (mode_reg == MODE_RESTORE_PAIR)
                            begin
                                zf_next = 1'b1;
                            end
                            if (mode_reg == MODE_SAVE_PAIR)
                            begin
                                if (step_reg != '0)
                                begin
                                    mark_step_next = step_reg - 1'b1;
                                    mark_pend_next = 1'b1;
                                end
                                else
                                begin
                                    mark_step_next = step_reg;
                                    mark_pend_next = 1'b0;
                                end
                                state_next = S_MRD;
                            end
                        end
                    end
                    MODE_SAVE_STEP, MODE_GET_STEP:
                    begin
                        fv_next = 1'b1;
                        fs_next = slot_one;
                        if (mode_reg == MODE_SAVE_STEP)
                        begin
                            mark_step_next = step_reg;
                            mark_pend_next = 1'b0;
                            state_next     = S_MRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_MRD:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_row        = mark_row;
                state_next    = S_MWR;
            end

            S_MWR:
            begin
                // The row is written back before the next read, so a second mark in
                // the same row sees the first.
                mem_ctl.wr_en = 1'b1;
                if (mark_pend_reg)
                begin
                    mark_step_next = step_reg;
                    mark_pend_next = 1'b0;
                    state_next     = S_MRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_QRD:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_row        = step_row;
                state_next    = S_QCHK;
            end

            S_QCHK:
            begin
                state_next = S_FIN;
                if (rd_data[step_bit])
                begin
                    as_next = 1'b1;
                end
                else if (below_found)
                begin
                    near_next = NEAR_W'({step_row, below_bit});
                end
                else if (low_found)
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_row        = low_row;
                    low_row_next  = low_row;
                    state_next    = S_QLOW;
                end
            end

            S_QLOW:
            begin
                near_next  = NEAR_W'({low_row_reg, top_bit});
                state_next = S_FIN;
            end

            S_FIN:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, near_reg, as_reg, zf_reg, ss_reg,
                                      sv_reg, fs_reg, fv_reg, oor_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_steps_reg <= NUM_STEPS_RST;
            interval_reg  <= INTERVAL_RST;
            base_reg      <= BASE_RST;
            mark_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_steps_reg <= num_steps_next;
            interval_reg  <= interval_next;
            base_reg      <= base_next;
            mark_pend_reg <= mark_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        step_reg      <= step_next;
        mark_step_reg <= mark_step_next;
        low_row_reg   <= low_row_next;
        oor_reg       <= oor_next;
        fv_reg        <= fv_next;
        fs_reg        <= fs_next;
        sv_reg        <= sv_next;
        ss_reg        <= ss_next;
        zf_reg        <= zf_next;
        as_reg        <= as_next;
        near_reg      <= near_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Quotient and remainder of the step by the effective interval.
    ckpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_step),
        .divisor  (d_eff),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // Stored marks, one bit per step, kept in rows.
    ckpt_marks #(
        .MAX_STEPS (MAX_STEPS)
    ) u_marks (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .rd_row   (rd_row),
        .wr_row   (mark_row),
        .wr_data  (mark_wdata),
        .rd_data  (rd_data),
        .occupied (occupied)
    );

endmodule

// ----- tb/tb_checkpoint_slot_manager_top.sv -----
// Self-checking testbench for the checkpoint slot manager against a slot and mark predictor.
module tb_checkpoint_slot_manager_top
    import ckpt_pkg::*;
;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    // Settling margin after the queues drain, well over the longest request.
    localparam int SETTLE_CYCLES = 40;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 400;
    // Watchdog limit, with a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT   = 400000;
    // Mismatch lines printed before the report goes quiet (counting continues).
    localparam int PRINT_LIMIT   = 40;

    // The two mode codes the package leaves unassigned.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // One result transaction, laid out as on m_axis_tdata (first member is the top bits).
    typedef struct packed {
        logic [OUT_PAD_W-1:0] spare;
        logic [NEAR_W-1:0]    nearest_stored;
        logic                 already_stored;
        logic                 zero_fill;
        logic [SLOT_W-1:0]    second_slot;
        logic                 second_valid;
        logic [SLOT_W-1:0]    first_slot;
        logic                 first_valid;
        logic                 out_of_range;
    } slot_result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [STEP_W-1:0] step;
    } slot_request_t;

    // Clock, reset and every block input start at a known value.
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    // Predictor copy of the register file and of the stored-marks table.
    logic [NSTEPS_W-1:0]      steps_in_use = NUM_STEPS_RST;
    logic [STEP_W-1:0]        spacing      = INTERVAL_RST;
    logic [SLOT_W-1:0]        rot_base     = BASE_RST;
    logic [MAX_STEPS_DEF-1:0] stored_mark  = '0;

    slot_request_t pending_requests[$];
    slot_result_t  expected_results[$];

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    logic        hold_off       = 1'b0;

    int           mismatch_count = 0;
    int           result_count   = 0;
    int           cycle_count    = 0;
    slot_result_t seen_result;
    slot_result_t due_result;

    checkpoint_slot_manager_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // Interval as the block uses it: anything below three counts as three.
    function automatic int unsigned eff_spacing();
        return (spacing < MIN_INTERVAL) ? int'(MIN_INTERVAL) : int'(spacing);
    endfunction

    // Storage slot of a time step: checkpoint steps and their predecessors own
    // fixed slots, all other steps share the rotating group starting at rot_base.
    function automatic logic [SLOT_W-1:0] slot_of_step(input int unsigned s);
        int unsigned d;
        int unsigned r;
        d = eff_spacing();
        if (s % d == 0)
            r = 2 * (s / d);
        else if ((s + 1) % d == 0)
            r = 2 * ((s + 1) / d) - 1;
        else
            r = rot_base + (s % d) - 1;
        return r[SLOT_W-1:0];
    endfunction

    // Works out the result of one accepted request and applies its effect on
    // the marks. Fields that mean nothing stay zero, nearest_stored stays -1.
    function automatic slot_result_t predict_slot_result(input slot_request_t req);
        slot_result_t res;
        int unsigned  d;
        int           k;
        logic         found;
        res                = '0;
        res.nearest_stored = NEAR_NONE;
        d                  = eff_spacing();
        found              = 1'b0;
        if (req.mode == MODE_CLEAR)
        begin
            stored_mark = '0;
        end
        else if (req.mode == MODE_SPARE_LO || req.mode == MODE_SPARE_HI)
        begin
            // Unassigned codes do nothing and flag nothing.
        end
        else if (req.step >= steps_in_use)
        begin
            res.out_of_range = 1'b1;
        end
        else if (req.mode == MODE_SAVE_PAIR || req.mode == MODE_RESTORE_PAIR)
        begin
            // Only checkpoint steps take part in pair transfers.
            if (req.step % d == 0)
            begin
                res.second_valid = 1'b1;
                res.second_slot  = slot_of_step(req.step);
                if (req.step != 0)
                begin
                    res.first_valid = 1'b1;
                    res.first_slot  = slot_of_step(req.step - 1);
                end
                else if (req.mode == MODE_RESTORE_PAIR)
                begin
                    res.zero_fill = 1'b1;
                end
                if (req.mode == MODE_SAVE_PAIR)
                begin
                    if (req.step != 0)
                        stored_mark[req.step - 1] = 1'b1;
                    stored_mark[req.step] = 1'b1;
                end
            end
        end
        else if (req.mode == MODE_SAVE_STEP || req.mode == MODE_GET_STEP)
        begin
            res.first_valid = 1'b1;
            res.first_slot  = slot_of_step(req.step);
            if (req.mode == MODE_SAVE_STEP)
                stored_mark[req.step] = 1'b1;
        end
        else
        begin
            if (stored_mark[req.step])
            begin
                res.already_stored = 1'b1;
            end
            else
            begin
                for (k = int'(req.step); k >= 0 && !found; k--)
                begin
                    if (stored_mark[k])
                    begin
                        found              = 1'b1;
                        res.nearest_stored = k[NEAR_W-1:0];
                    end
                end
            end
        end
        return res;
    endfunction

    // Prints one line per mismatch (up to a limit) and counts every one.
    task automatic report_mismatch(input string what, input int unsigned got_val,
                                   input int unsigned want_val);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $time, result_count, what, got_val, want_val);
    endtask

    // Driver: a transaction on the request side is predicted at the edge that
    // accepts it. tvalid stays up until accepted and is assigned once per edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(predict_slot_result(
                    slot_request_t'{mode: s_axis_tuser, step: s_axis_tdata[STEP_W-1:0]}));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_requests[0].mode;
                    s_axis_tdata  <= IN_DATA_W'(pending_requests[0].step);
                    void'(pending_requests.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result = slot_result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected, low data",
                                    m_axis_tdata[31:0], 0);
                end
                else
                begin
                    due_result = expected_results.pop_front();
                    if (seen_result.out_of_range != due_result.out_of_range)
                        report_mismatch("out_of_range", seen_result.out_of_range,
                                        due_result.out_of_range);
                    if (seen_result.first_valid != due_result.first_valid)
                        report_mismatch("first_valid", seen_result.first_valid,
                                        due_result.first_valid);
                    if (seen_result.first_slot != due_result.first_slot)
                        report_mismatch("first_slot", seen_result.first_slot,
                                        due_result.first_slot);
                    if (seen_result.second_valid != due_result.second_valid)
                        report_mismatch("second_valid", seen_result.second_valid,
                                        due_result.second_valid);
                    if (seen_result.second_slot != due_result.second_slot)
                        report_mismatch("second_slot", seen_result.second_slot,
                                        due_result.second_slot);
                    if (seen_result.zero_fill != due_result.zero_fill)
                        report_mismatch("zero_fill", seen_result.zero_fill,
                                        due_result.zero_fill);
                    if (seen_result.already_stored != due_result.already_stored)
                        report_mismatch("already_stored", seen_result.already_stored,
                                        due_result.already_stored);
                    if (seen_result.nearest_stored != due_result.nearest_stored)
                        report_mismatch("nearest_stored", seen_result.nearest_stored,
                                        due_result.nearest_stored);
                    if (seen_result.spare != due_result.spare)
                        report_mismatch("padding bits", seen_result.spare, due_result.spare);
                end
                result_count++;
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Receiver hold-off: once requested, tready stays low for a fixed stretch
    // while the sender keeps offering, so the block backs up and stalls its input.
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_request(input logic [MODE_W-1:0] mode, input int unsigned step);
        slot_request_t req;
        req.mode = mode;
        req.step = STEP_W'(step);
        pending_requests.push_back(req);
    endtask

    // Waits until every request has been sent and every result has come back,
    // then lets the block settle so that a register write finds it idle. The
    // queues are looked at on the falling edge, when the clocked processes of
    // the rising edge have all updated them.
    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_NUM_STEPS: steps_in_use = NSTEPS_W'(value);
            CFG_INTERVAL:  spacing      = STEP_W'(value);
            CFG_BASE:      rot_base     = SLOT_W'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // New register setting and new idling pattern, applied with the block idle.
    task automatic start_phase(input int unsigned nsteps, input int unsigned intv,
                               input int unsigned base, input int unsigned sidle,
                               input int unsigned rstall);
        wait_until_drained();
        write_cfg(CFG_NUM_STEPS, nsteps);
        write_cfg(CFG_INTERVAL, intv);
        write_cfg(CFG_BASE, base);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
    endtask

    // Random request mix for the current setting. Pair requests mostly hit
    // checkpoint steps so that marks build up and queries find real neighbors.
    task automatic queue_random_requests(input int count);
        int unsigned   span;
        int unsigned   d;
        int unsigned   pick;
        slot_request_t req;
        span = (steps_in_use > MAX_STEPS_DEF) ? MAX_STEPS_DEF : steps_in_use;
        d    = eff_spacing();
        for (int i = 0; i < count; i++)
        begin
            pick     = $urandom_range(99);
            req.step = STEP_W'($urandom_range(STEP_SPACE - 1));
            if (pick < 3)
            begin
                req.mode = MODE_CLEAR;
            end
            else if (pick < 6)
            begin
                req.mode = pick[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
            end
            else if (span == 0 || pick < 14)
            begin
                // Any step mode, with an out-of-range step where the range ends below the step space.
                req.mode = MODE_W'($urandom_range(MODE_QUERY));
                if (span < STEP_SPACE)
                    req.step = STEP_W'($urandom_range(STEP_SPACE - 1, span));
            end
            else
            begin
                req.step = STEP_W'($urandom_range(span - 1));
                if (pick < 42)
                begin
                    req.mode = (pick < 30) ? MODE_SAVE_PAIR : MODE_RESTORE_PAIR;
                    if ($urandom_range(9) < 8)
                        req.step = STEP_W'(d * $urandom_range((span - 1) / d));
                end
                else if (pick < 56)
                begin
                    req.mode = MODE_SAVE_STEP;
                end
                else if (pick < 68)
                begin
                    req.mode = MODE_GET_STEP;
                end
                else
                begin
                    req.mode = MODE_QUERY;
                end
            end
            pending_requests.push_back(req);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset setting (4096 steps, interval 3, base 0).
        queue_request(MODE_CLEAR, 4095);
        queue_request(MODE_QUERY, 4095);          // nothing marked: -1
        queue_request(MODE_SAVE_PAIR, 0);         // step zero has no predecessor
        queue_request(MODE_RESTORE_PAIR, 0);      // zero fill
        queue_request(MODE_SAVE_PAIR, 3);
        queue_request(MODE_SAVE_PAIR, 4);         // not a checkpoint: no action
        queue_request(MODE_RESTORE_PAIR, 3);
        queue_request(MODE_SAVE_STEP, 4095);
        queue_request(MODE_GET_STEP, 1);          // rotating slot
        queue_request(MODE_GET_STEP, 2);          // predecessor of a checkpoint
        queue_request(MODE_QUERY, 1);             // nearest is step zero
        queue_request(MODE_QUERY, 4094);          // nearest is step three
        queue_request(MODE_QUERY, 4095);          // step itself stored
        queue_request(MODE_SPARE_LO, 5);
        queue_request(MODE_SPARE_HI, 4095);
        wait_until_drained();

        // Short range, an interval below the minimum, top rotating base.
        write_cfg(CFG_NUM_STEPS, 100);
        write_cfg(CFG_INTERVAL, 0);
        write_cfg(CFG_BASE, 4095);
        queue_request(MODE_SAVE_STEP, 100);       // first step out of range
        queue_request(MODE_QUERY, 4095);
        queue_request(MODE_RESTORE_PAIR, 99);
        queue_request(MODE_GET_STEP, 98);
        queue_request(MODE_GET_STEP, 97);         // rotating slot at the top base
        queue_request(MODE_SAVE_PAIR, 100);
        wait_until_drained();

        // Largest interval: slots wrap past the top of the slot space.
        write_cfg(CFG_NUM_STEPS, 4096);
        write_cfg(CFG_INTERVAL, 4095);
        queue_request(MODE_GET_STEP, 4093);
        queue_request(MODE_SAVE_PAIR, 4095);
        queue_request(MODE_RESTORE_PAIR, 0);

        // Random phases across settings and idling patterns.
        start_phase(4096, 90, 92, 0, 0);
        queue_random_requests(300);
        start_phase(1000, 45, 46, 79, 0);
        queue_random_requests(250);
        start_phase(200, 20, 22, 0, 79);
        queue_random_requests(250);
        start_phase(4096, 3, 0, 24, 24);
        queue_random_requests(250);

        // Back-pressure phase: the sender keeps offering while the receiver holds off.
        start_phase(13, 5, 8, 0, 0);
        hold_request = 1'b1;
        queue_random_requests(250);

        start_phase(8191, 4095, 4095, 24, 24);
        queue_random_requests(250);
        start_phase(1, 1, 0, 79, 0);
        queue_random_requests(100);
        start_phase(0, 2, 4095, 0, 79);
        queue_random_requests(50);

        wait_until_drained();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ckpt_pkg.sv
design/ckpt_div.sv
design/ckpt_marks.sv
design/checkpoint_slot_manager_top.sv
tb/tb_checkpoint_slot_manager_top.sv
